// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every edge outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication checked in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/ncd_pkg.sv =====
package ncd_pkg;
   localparam int DefMaxEdges    = 256;
   localparam int DefMaxVertices = 64;
   localparam int VcountWidth    = 7;
   localparam int WeightWidth    = 16;
   localparam int VertexWidth    = 6;
   localparam int DistWidth      = 32;

   // Controller commands to the datapath
   typedef struct packed {
      logic store_edge;    // write the incoming edge
      logic clear_graph;   // drop count and overflow, clear reached marks
      logic init_dist;     // set distances for a new run
      logic rd_edge;       // issue edge read
      logic rd_dist;       // read both endpoint distances of the edge read
      logic relax;         // evaluate edge from read data
      logic apply;         // apply relaxation (not check pass)
      logic mark;          // mark reached vertices
      logic clr_found;     // clear relax-found flag
   } ncd_cmd_type;

   typedef struct packed {
      logic found;
   } ncd_stat_type;
endpackage

// ===== rtl/ncd_if.sv =====
interface ncd_req_if;
   import ncd_pkg::*;
   logic                          valid;
   logic                          ready;
   logic [VertexWidth-1:0]        edge_source;
   logic [VertexWidth-1:0]        edge_dest;
   logic signed [WeightWidth-1:0] edge_weight;
   logic                          last_edge;
   modport source (output valid, edge_source, edge_dest, edge_weight, last_edge,
                   input ready);
   modport sink (input valid, edge_source, edge_dest, edge_weight, last_edge,
                 output ready);
endinterface

interface ncd_rsp_if;
   logic valid;
   logic ready;
   logic has_negative_cycle;
   logic edges_dropped;
   modport source (output valid, has_negative_cycle, edges_dropped, input ready);
   modport sink (input valid, has_negative_cycle, edges_dropped, output ready);
endinterface

// ===== rtl/ncd_datapath.sv =====
module ncd_datapath
   import ncd_pkg::*;
#(
   parameter int MaxEdges    = DefMaxEdges,
   parameter int MaxVertices = DefMaxVertices
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ncd_cmd_type                   cmd,
   input  logic [VertexWidth-1:0]        in_src,
   input  logic [VertexWidth-1:0]        in_dst,
   input  logic signed [WeightWidth-1:0] in_wt,
   input  logic [$clog2(MaxEdges+1)-1:0] rd_addr,
   input  logic [$clog2(MaxVertices+1)-1:0] vlim,
   input  logic [$clog2(MaxVertices)-1:0] vidx,
   input  logic [$clog2(MaxVertices)-1:0] run_src,
   output logic [$clog2(MaxEdges+1)-1:0] edge_count,
   output logic                          overflow,
   output logic                          reached_now,
   output ncd_stat_type                  stat
);
   localparam int EW = $clog2(MaxEdges+1);
   localparam int AW = $clog2(MaxEdges);
   localparam int VW = $clog2(MaxVertices);
   localparam int RecW = 2*VertexWidth + WeightWidth;

   logic [RecW-1:0] mem [MaxEdges];
   logic [RecW-1:0] rd_ff;
   logic [EW-1:0] count_ff, count_in;
   logic ovf_ff, ovf_in;
   logic [MaxVertices-1:0] reached_ff, inf_ff;
   logic signed [DistWidth-1:0] dist_mem [MaxVertices];
   logic signed [DistWidth-1:0] da_ff, db_ff;
   logic found_ff;
   logic [VertexWidth-1:0] ea, eb;
   logic signed [WeightWidth-1:0] ew;
   logic [VW-1:0] ia, ib;
   logic signed [DistWidth:0] sum;
   logic signed [DistWidth-1:0] sat;
   logic in_range, go;

   // Edge store write and registered read
   always_ff @(posedge clock) begin
      if (cmd.store_edge && count_ff < EW'(MaxEdges))
         mem[count_ff[AW-1:0]] <= {in_src, in_dst, in_wt};
      if (cmd.rd_edge)
         rd_ff <= mem[rd_addr[AW-1:0]];
   end

   // Count and overflow
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (cmd.store_edge) begin
         if (count_ff < EW'(MaxEdges)) count_in = count_ff + 1'b1;
         else ovf_in = 1'b1;
      end
      if (cmd.clear_graph) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end
   end

   // Relaxation of the edge just read
   assign ea  = rd_ff[RecW-1 -: VertexWidth];
   assign eb  = rd_ff[WeightWidth +: VertexWidth];
   assign ew  = rd_ff[WeightWidth-1:0];
   assign ia  = VW'(ea);
   assign ib  = VW'(eb);
   assign in_range = ({1'b0, ea} < (VertexWidth+1)'(vlim)) &&
                     ({1'b0, eb} < (VertexWidth+1)'(vlim));

   // Read both endpoint distances into registers
   always_ff @(posedge clock) begin
      if (cmd.rd_dist) begin
         da_ff <= dist_mem[ia];
         db_ff <= dist_mem[ib];
      end
   end

   assign sum = (DistWidth+1)'(da_ff) + (DistWidth+1)'(ew);
   always_comb begin
      if (sum[DistWidth] != sum[DistWidth-1])
         sat = sum[DistWidth] ? {1'b1, {(DistWidth-1){1'b0}}}
                              : {1'b0, {(DistWidth-1){1'b1}}};
      else
         sat = sum[DistWidth-1:0];
   end
   assign go = cmd.relax && in_range && !inf_ff[ia] && (inf_ff[ib] || sat < db_ff);

   always_ff @(posedge clock) begin
      if (cmd.init_dist) begin
         inf_ff[vidx]   <= (vidx != run_src);
         dist_mem[vidx] <= '0;
      end else if (go && cmd.apply) begin
         inf_ff[ib]   <= 1'b0;
         dist_mem[ib] <= sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         reached_ff <= '0;
         found_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         if (cmd.clear_graph) reached_ff <= '0;
         else if (cmd.mark && !inf_ff[vidx]) reached_ff[vidx] <= 1'b1;
         if (cmd.clr_found) found_ff <= 1'b0;
         else if (go) found_ff <= 1'b1;
      end
   end

   assign edge_count  = count_ff;
   assign overflow    = ovf_ff;
   assign reached_now = reached_ff[vidx];
   assign stat.found  = found_ff;
endmodule

// ===== rtl/ncd_ctrl.sv =====
module ncd_ctrl
   import ncd_pkg::*;
#(
   parameter int MaxEdges    = DefMaxEdges,
   parameter int MaxVertices = DefMaxVertices
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [VcountWidth-1:0]        vcount,
   input  logic                          req_valid,
   input  logic                          req_last,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_neg,
   output logic                          rsp_dropped,
   input  logic [$clog2(MaxEdges+1)-1:0] edge_count,
   input  logic                          overflow,
   input  logic                          reached_now,
   input  ncd_stat_type                  stat,
   output ncd_cmd_type                   cmd,
   output logic [$clog2(MaxEdges+1)-1:0] rd_addr,
   output logic [$clog2(MaxVertices+1)-1:0] vlim,
   output logic [$clog2(MaxVertices)-1:0] vidx,
   output logic [$clog2(MaxVertices)-1:0] run_src
);
   `include "assert_macros.svh"
   localparam int EW  = $clog2(MaxEdges+1);
   localparam int VW  = $clog2(MaxVertices);
   localparam int VCW = $clog2(MaxVertices+1);

   localparam logic [2:0] S_LOAD = 3'd0, S_PICK = 3'd1, S_INIT = 3'd2,
                          S_RD = 3'd3, S_EVAL = 3'd4, S_MARK = 3'd5,
                          S_OUT = 3'd6, S_DRD = 3'd7;

   logic [2:0]     state_ff, state_in;
   logic [EW-1:0]  edge_ff, edge_in;
   logic [VCW-1:0] pass_ff, pass_in, vlim_ff, vlim_in;
   logic [VW-1:0]  vidx_ff, vidx_in, src_ff, src_in;
   logic           neg_ff, neg_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_neg_ff, rsp_neg_in;
   logic           rsp_drop_ff, rsp_drop_in;
   logic           last_v, last_e, check;

   assign last_v = ({1'b0, vidx_ff} == vlim_ff - 1'b1);
   assign last_e = (edge_ff + 1'b1 >= edge_count);
   assign check  = (pass_ff + 1'b1 >= vlim_ff);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      edge_in  = edge_ff;
      pass_in  = pass_ff;
      vlim_in  = vlim_ff;
      vidx_in  = vidx_ff;
      src_in   = src_ff;
      neg_in   = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_neg_in   = rsp_neg_ff;
      rsp_drop_in  = rsp_drop_ff;
      cmd      = '0;
      req_ready = (state_ff == S_LOAD);
      unique case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               cmd.store_edge = 1'b1;
               if (req_last) begin
                  state_in = S_PICK;
                  vidx_in  = '0;
                  neg_in   = 1'b0;
                  if (vcount == '0) vlim_in = VCW'(1);
                  else if (32'(vcount) > MaxVertices) vlim_in = VCW'(MaxVertices);
                  else vlim_in = VCW'(vcount);
               end
            end
         end
         S_PICK: begin
            if (reached_now) begin
               if (last_v) state_in = S_OUT;
               else vidx_in = vidx_ff + 1'b1;
            end else begin
               src_in   = vidx_ff;
               vidx_in  = '0;
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            cmd.init_dist = 1'b1;
            if (last_v) begin
               pass_in  = '0;
               edge_in  = '0;
               cmd.clr_found = 1'b1;
               state_in = (edge_count == '0) ? S_MARK : S_RD;
               vidx_in  = '0;
            end else vidx_in = vidx_ff + 1'b1;
         end
         S_RD: begin
            cmd.rd_edge = 1'b1;
            state_in = S_DRD;
         end
         S_DRD: begin
            cmd.rd_dist = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.relax = 1'b1;
            cmd.apply = !check;
            if (!last_e) begin
               edge_in  = edge_ff + 1'b1;
               state_in = S_RD;
            end else if (!check) begin
               // start next pass with the found flag clear
               cmd.clr_found = 1'b1;
               edge_in  = '0;
               pass_in  = pass_ff + 1'b1;
               state_in = S_RD;
            end else begin
               state_in = S_MARK;
               vidx_in  = '0;
            end
         end
         S_MARK: begin
            // found flag covers the check pass only
            if (stat.found && check) begin
               neg_in   = 1'b1;
               state_in = S_OUT;
            end else begin
               cmd.mark = 1'b1;
               if (last_v) begin
                  vidx_in  = (src_ff == VW'(vlim_ff - 1'b1)) ? src_ff : src_ff + 1'b1;
                  state_in = (src_ff == VW'(vlim_ff - 1'b1)) ? S_OUT : S_PICK;
               end else vidx_in = vidx_ff + 1'b1;
            end
         end
         S_OUT: begin
            // move the verdict into the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_neg_in   = neg_ff;
               rsp_drop_in  = overflow;
               cmd.clear_graph = 1'b1;
               state_in = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         neg_ff       <= neg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      edge_ff <= edge_in;
      pass_ff <= pass_in;
      vlim_ff <= vlim_in;
      vidx_ff <= vidx_in;
      src_ff  <= src_in;
      rsp_neg_ff  <= rsp_neg_in;
      rsp_drop_ff <= rsp_drop_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_neg     = rsp_neg_ff;
   assign rsp_dropped = rsp_drop_ff;
   assign rd_addr     = edge_ff;
   assign vlim        = vlim_ff;
   assign vidx        = vidx_ff;
   assign run_src     = src_ff;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NEXT(a_rd_dist, clock, reset, cmd.rd_edge, cmd.rd_dist)
   `ASSERT_NEXT(a_dist_eval, clock, reset, cmd.rd_dist, cmd.relax)
   `ASSERT_IMPLY(a_no_apply_check, clock, reset, cmd.relax && check, !cmd.apply)
endmodule

// ===== rtl/negative_cycle_detector_top.sv =====
// When ready, loads one edge per cycle into the edge store; the last edge starts detection.
// Each run from an unreached source initialises V distances, makes V passes over the edges
// (store read, distance read, relax) with the last as check pass, and marks reached vertices;
// a pick step per scanned vertex finds the next source. The verdict then enters an output
// register and loading resumes, once an earlier verdict waiting there has been taken.
// Synchronous active-high reset clears counts, reached marks and sets vertex count to 64.
module negative_cycle_detector_top
   import ncd_pkg::*;
#(
   parameter int MaxEdges    = DefMaxEdges,
   parameter int MaxVertices = DefMaxVertices
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [VcountWidth-1:0] csr_write_data,
   ncd_req_if.sink                req,
   ncd_rsp_if.source              rsp
);
   logic [VcountWidth-1:0] vcount_ff;
   logic [$clog2(MaxEdges+1)-1:0] edge_count, rd_addr;
   logic [$clog2(MaxVertices+1)-1:0] vlim;
   logic [$clog2(MaxVertices)-1:0] vidx, run_src;
   logic overflow, reached_now;
   ncd_cmd_type  cmd;
   ncd_stat_type stat;

   // Hold vertex count register
   always_ff @(posedge clock) begin
      if (reset) vcount_ff <= VcountWidth'(64);
      else if (csr_write_enable) vcount_ff <= csr_write_data;
   end

   ncd_ctrl #(.MaxEdges(MaxEdges), .MaxVertices(MaxVertices)) u_ctrl (
      .clock, .reset, .vcount(vcount_ff),
      .req_valid(req.valid), .req_last(req.last_edge), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_neg(rsp.has_negative_cycle),
      .rsp_dropped(rsp.edges_dropped),
      .edge_count, .overflow, .reached_now, .stat, .cmd, .rd_addr, .vlim, .vidx, .run_src);

   ncd_datapath #(.MaxEdges(MaxEdges), .MaxVertices(MaxVertices)) u_dp (
      .clock, .reset, .cmd,
      .in_src(req.edge_source), .in_dst(req.edge_dest), .in_wt(req.edge_weight),
      .rd_addr, .vlim, .vidx, .run_src, .edge_count, .overflow, .reached_now, .stat);
endmodule
